/* design/nru_pkg.sv */
// Package: shared constants, register codes and control/status types for the NRU unit.
`default_nettype none
package nru_pkg;

  localparam int NUM_FRAMES = 16;
  localparam int FRAME_W    = $clog2(NUM_FRAMES);
  localparam int NCNT_W     = $clog2(NUM_FRAMES + 1);

  localparam int ADDR_W     = 32;
  localparam int PAGE_W     = 32;
  localparam int SHIFT_W    = 4;
  localparam int FIU_W      = 5;
  localparam int CLR_W      = 16;
  localparam int FAULT_W    = 32;
  localparam int FRAME_OUT_W = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CLS_W      = 3;

  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST     = 4'd6;
  localparam logic [FIU_W-1:0]   FRAMES_IN_USE_RST  = 5'd16;
  localparam logic [CLR_W-1:0]   CLEAR_INTERVAL_RST = 16'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_INTERVAL = 2'd2;

  // no class seen yet: above R1M1
  localparam logic [CLS_W-1:0] CLS_NONE = 3'd4;

  typedef struct packed {
    logic load;    // latch the incoming word, restart the scan
    logic issue;   // read the next frame entry
    logic commit;  // apply the update and load the result register
  } nru_cmd_t;

  typedef struct packed {
    logic last_issue;  // scan index is at the last active frame
    logic out_free;    // result register can take a new word
  } nru_sts_t;

endpackage
`default_nettype wire

/* design/nru_page_replacement.sv */
// Top level of the not-recently-used page replacement unit.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------------
//  in      | to block  | in_valid_i / in_stall_o   | virtual_address_i, is_write_i
//  out     | from block| out_valid_o / out_stall_i | hit_o, frame_o, evicted_valid_o,
//          |           |                           | evicted_page_o, fault_total_o
//  cfg     | to block  | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// Each word is accepted in the idle state; the frame-page table is then scanned over the n
// active frames, n being the effective frame count (frames_in_use clamped to 1..NUM_FRAMES),
// one entry a cycle through the table RAM's single read port. A drain state follows for the
// registered read, then a commit state applies the update and loads the result register.
// A new word can be taken in the cycle after the previous result is loaded, even while that
// result still waits under out_stall_i; the commit holds only while the result register is
// full and out_stall_i is high. Reset clears the per-frame used/R/M bits and the counters
// and loads the config registers with their reset values at once; the frame-page table needs
// no clearing since an entry is compared only while its frame is used.
`default_nettype none
module nru_page_replacement (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration
  input  wire logic                           cfg_we_i,
  input  wire logic [nru_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [nru_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // access words
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [nru_pkg::ADDR_W-1:0]     virtual_address_i,
  input  wire logic                           is_write_i,
  // result words
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                hit_o,
  output logic [nru_pkg::FRAME_OUT_W-1:0]     frame_o,
  output logic                                evicted_valid_o,
  output logic [nru_pkg::PAGE_W-1:0]          evicted_page_o,
  output logic [nru_pkg::FAULT_W-1:0]         fault_total_o
);
  import nru_pkg::*;

  nru_cmd_t cmd;
  nru_sts_t sts;

  // sequence: accept, scan the active frames, drain the last read, commit
  nru_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // hold the table, the NRU bits, the counters and the result register
  nru_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .virtual_address_i (virtual_address_i),
    .is_write_i        (is_write_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .hit_o             (hit_o),
    .frame_o           (frame_o),
    .evicted_valid_o   (evicted_valid_o),
    .evicted_page_o    (evicted_page_o),
    .fault_total_o     (fault_total_o)
  );

endmodule
`default_nettype wire

/* design/nru_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module nru_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* design/nru_ctrl.sv */
// Controller: sequences accept, frame scan, drain and commit for one word.
`default_nettype none
module nru_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire nru_pkg::nru_sts_t sts_i,
  output nru_pkg::nru_cmd_t      cmd_o
);
  import nru_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_stall_o   = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last compare completes here
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* design/nru_dp.sv */
// Datapath: config registers, frame table, scan compare, NRU bits, counters, result register.
`default_nettype none
module nru_dp (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [nru_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [nru_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire logic [nru_pkg::ADDR_W-1:0]         virtual_address_i,
  input  wire logic                               is_write_i,
  input  wire nru_pkg::nru_cmd_t                  cmd_i,
  output nru_pkg::nru_sts_t                       sts_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    hit_o,
  output logic [nru_pkg::FRAME_OUT_W-1:0]         frame_o,
  output logic                                    evicted_valid_o,
  output logic [nru_pkg::PAGE_W-1:0]              evicted_page_o,
  output logic [nru_pkg::FAULT_W-1:0]             fault_total_o
);
  import nru_pkg::*;

  // configuration
  logic [SHIFT_W-1:0] page_shift_q;
  logic [FIU_W-1:0]   frames_in_use_q;
  logic [CLR_W-1:0]   clear_interval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q     <= PAGE_SHIFT_RST;
      frames_in_use_q  <= FRAMES_IN_USE_RST;
      clear_interval_q <= CLEAR_INTERVAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PAGE_SHIFT:     page_shift_q     <= cfg_wdata_i[SHIFT_W-1:0];
        CFG_FRAMES_IN_USE:  frames_in_use_q  <= cfg_wdata_i[FIU_W-1:0];
        CFG_CLEAR_INTERVAL: clear_interval_q <= cfg_wdata_i[CLR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // effective frame count: zero acts as one, clamp to the table size
  logic [NCNT_W-1:0] n_act;
  always_comb begin
    if (frames_in_use_q == '0) begin
      n_act = NCNT_W'(1);
    end else if (32'(frames_in_use_q) > 32'(NUM_FRAMES)) begin
      n_act = NCNT_W'(NUM_FRAMES);
    end else begin
      n_act = NCNT_W'(frames_in_use_q);
    end
  end

  // request
  logic [PAGE_W-1:0] page_q;
  logic              wr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q <= virtual_address_i >> page_shift_q;
      wr_q   <= is_write_i;
    end
  end

  // scan issue side
  logic [FRAME_W-1:0] idx_q;
  logic [FRAME_W-1:0] cmp_idx_q;
  logic               cmp_vld_q;
  logic [NCNT_W-1:0]  n_last;

  assign n_last           = n_act - NCNT_W'(1);
  assign sts_o.last_issue = (idx_q == FRAME_W'(n_last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.issue;
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.issue) begin
        idx_q <= idx_q + FRAME_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      cmp_idx_q <= idx_q;
    end
  end

  // frame table
  logic               ram_we;
  logic [FRAME_W-1:0] slot;
  logic [PAGE_W-1:0]  ram_rdata;

  nru_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (NUM_FRAMES)
  ) u_frame_page (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (page_q),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // per-frame state bits
  logic [NUM_FRAMES-1:0] used_q, used_d;
  logic [NUM_FRAMES-1:0] ref_q, ref_d;
  logic [NUM_FRAMES-1:0] mod_q, mod_d;

  // scan results
  logic               hit_q;
  logic [FRAME_W-1:0] hit_idx_q;
  logic               free_q;
  logic [FRAME_W-1:0] free_idx_q;
  logic [CLS_W-1:0]   best_cls_q;
  logic [FRAME_W-1:0] best_idx_q;
  logic [PAGE_W-1:0]  best_page_q;

  logic               cmp_used;
  logic [CLS_W-1:0]   cmp_cls;

  assign cmp_used = used_q[cmp_idx_q];
  assign cmp_cls  = {1'b0, ref_q[cmp_idx_q], mod_q[cmp_idx_q]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      best_cls_q <= CLS_NONE;
    end else if (cmd_i.load) begin
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      best_cls_q <= CLS_NONE;
    end else if (cmp_vld_q) begin
      // lowest matching frame wins
      if (cmp_used && (ram_rdata == page_q) && !hit_q) begin
        hit_q <= 1'b1;
      end
      if (!cmp_used && !free_q) begin
        free_q <= 1'b1;
      end
      if (cmp_used && (cmp_cls < best_cls_q)) begin
        best_cls_q <= cmp_cls;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      best_idx_q <= '0;
      best_page_q <= '0;
    end else if (cmp_vld_q) begin
      if (cmp_used && (ram_rdata == page_q) && !hit_q) begin
        hit_idx_q <= cmp_idx_q;
      end
      if (!cmp_used && !free_q) begin
        free_idx_q <= cmp_idx_q;
      end
      if (cmp_used && (cmp_cls < best_cls_q)) begin
        best_idx_q  <= cmp_idx_q;
        best_page_q <= ram_rdata;
      end
    end
  end

  // commit
  logic [CLR_W-1:0]   acc_q, acc_d, acc_inc;
  logic [FAULT_W-1:0] fault_q, fault_d;
  logic               evict;

  assign evict   = !hit_q && !free_q;
  assign ram_we  = cmd_i.commit && !hit_q;
  assign acc_inc = acc_q + CLR_W'(1);

  always_comb begin
    if (hit_q) begin
      slot = hit_idx_q;
    end else if (free_q) begin
      slot = free_idx_q;
    end else begin
      slot = best_idx_q;
    end
  end

  always_comb begin
    used_d  = used_q;
    ref_d   = ref_q;
    mod_d   = mod_q;
    fault_d = fault_q;
    acc_d   = acc_q;
    if (cmd_i.commit) begin
      ref_d[slot] = 1'b1;
      if (hit_q) begin
        mod_d[slot] = mod_q[slot] | wr_q;
      end else begin
        used_d[slot] = 1'b1;
        mod_d[slot]  = wr_q;
        if (fault_q != '1) begin
          fault_d = fault_q + FAULT_W'(1);
        end
      end
      // clear follows the access, so it drops the R bit just set too
      acc_d = acc_inc;
      if ((clear_interval_q != '0) && (acc_inc >= clear_interval_q)) begin
        ref_d = '0;
        acc_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      ref_q   <= '0;
      mod_q   <= '0;
      fault_q <= '0;
      acc_q   <= '0;
    end else begin
      used_q  <= used_d;
      ref_q   <= ref_d;
      mod_q   <= mod_d;
      fault_q <= fault_d;
      acc_q   <= acc_d;
    end
  end

  // result register
  logic out_valid_q;

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_o           <= hit_q;
      frame_o         <= FRAME_OUT_W'(slot);
      evicted_valid_o <= evict;
      evicted_page_o  <= evict ? best_page_q : '0;
      fault_total_o   <= fault_d;
    end
  end

endmodule
`default_nettype wire

/* design/nru_checker.sv */
// Port-level checker for the NRU unit and its bind to the top level.
`default_nettype none
module nru_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        hit_o,
  input wire logic [3:0]  frame_o,
  input wire logic        evicted_valid_o,
  input wire logic [31:0] evicted_page_o,
  input wire logic [31:0] fault_total_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_o) && $stable(frame_o)
      && $stable(evicted_valid_o) && $stable(evicted_page_o) && $stable(fault_total_o))
    else $error("result word changed while stalled");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !evicted_valid_o && (evicted_page_o == 32'd0))
    else $error("hit reported an eviction");

  // a miss has counted at least one fault
  a_miss_faults: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> fault_total_o != 32'd0)
    else $error("miss with zero fault count");

  // an accepted word keeps the block busy on the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word accepted back to back");

endmodule

bind nru_page_replacement nru_checker u_nru_checker (.*);
`default_nettype wire

/* tb/tb.sv */
// Testbench for the NRU page replacement unit: scoreboard, stimulus and response checks.
`timescale 1ns / 1ps

module tb;
  import nru_pkg::*;

  localparam int CYCLE_LIMIT    = 600000;
  localparam int PHASES         = 11;
  localparam int WORDS_PER_PHASE = 150;
  localparam int LONG_HOLD      = 400;

  // One result word as the block reports it.
  typedef struct packed {
    logic                   hit;
    logic [FRAME_OUT_W-1:0] frame;
    logic                   evicted_valid;
    logic [PAGE_W-1:0]      evicted_page;
    logic [FAULT_W-1:0]     fault_total;
  } nru_result_t;

  // Shadow copy of the frame table plus the queue of results still owed.
  class frame_table_scoreboard;
    logic [SHIFT_W-1:0] page_shift;
    logic [FIU_W-1:0]   frames_in_use;
    logic [CLR_W-1:0]   clear_interval;
    logic [PAGE_W-1:0]  frame_page [NUM_FRAMES];
    bit                 frame_used [NUM_FRAMES];
    bit                 ref_bit    [NUM_FRAMES];
    bit                 mod_bit    [NUM_FRAMES];
    logic [CLR_W-1:0]   access_count;
    logic [FAULT_W-1:0] fault_count;
    nru_result_t        owed_results [$];
    int                 mismatches;
    int                 words_checked;
    int                 hits_seen;
    int                 evictions_seen;

    function new();
      page_shift     = PAGE_SHIFT_RST;
      frames_in_use  = FRAMES_IN_USE_RST;
      clear_interval = CLEAR_INTERVAL_RST;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        frame_page[i] = '0;
        frame_used[i] = 1'b0;
        ref_bit[i]    = 1'b0;
        mod_bit[i]    = 1'b0;
      end
      access_count   = '0;
      fault_count    = '0;
      mismatches     = 0;
      words_checked  = 0;
      hits_seen      = 0;
      evictions_seen = 0;
    endfunction

    function int effective_frames();
      if (frames_in_use == 0) return 1;
      if (frames_in_use > NUM_FRAMES) return NUM_FRAMES;
      return int'(frames_in_use);
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PAGE_SHIFT:     page_shift     = data[SHIFT_W-1:0];
        CFG_FRAMES_IN_USE:  frames_in_use  = data[FIU_W-1:0];
        CFG_CLEAR_INTERVAL: clear_interval = data[CLR_W-1:0];
        default: ;
      endcase
    endfunction

    // Predict the result of one accepted access and update the shadow table.
    function void note_access(input logic [ADDR_W-1:0] addr, input logic wr);
      logic [PAGE_W-1:0] page;
      int                n;
      int                slot;
      int                best_cls;
      int                cls;
      int                i;
      bit                found;
      nru_result_t       r;
      page  = addr >> page_shift;
      n     = effective_frames();
      slot  = 0;
      found = 1'b0;
      r     = '0;
      // Search active frames only; the lowest matching frame wins.
      for (i = 0; i < n; i++) begin
        if (!found && frame_used[i] && frame_page[i] == page) begin
          found = 1'b1;
          slot  = i;
        end
      end
      if (found) begin
        r.hit         = 1'b1;
        ref_bit[slot] = 1'b1;
        if (wr) mod_bit[slot] = 1'b1;
        hits_seen++;
      end else begin
        if (fault_count != '1) fault_count++;
        found = 1'b0;
        for (i = 0; i < n; i++) begin
          if (!found && !frame_used[i]) begin
            found = 1'b1;
            slot  = i;
          end
        end
        if (!found) begin
          // Lowest NRU class, lowest frame inside that class.
          best_cls = 4;
          for (i = 0; i < n; i++) begin
            cls = (int'(ref_bit[i]) << 1) | int'(mod_bit[i]);
            if (frame_used[i] && cls < best_cls) begin
              best_cls = cls;
              slot     = i;
            end
          end
          r.evicted_valid = 1'b1;
          r.evicted_page  = frame_page[slot];
          evictions_seen++;
        end
        frame_page[slot] = page;
        frame_used[slot] = 1'b1;
        ref_bit[slot]    = 1'b1;
        mod_bit[slot]    = wr;
      end
      // The clear comes after the access, so it also drops the R bit just set.
      access_count = access_count + 1'b1;
      if (clear_interval != 0 && access_count >= clear_interval) begin
        for (i = 0; i < NUM_FRAMES; i++) ref_bit[i] = 1'b0;
        access_count = '0;
      end
      r.frame       = slot[FRAME_OUT_W-1:0];
      r.fault_total = fault_count;
      owed_results.push_back(r);
    endfunction

    function void check_result(input nru_result_t got);
      nru_result_t want;
      words_checked++;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result word with nothing owed: hit=%0b frame=%0d ev=%0b page=%h faults=%0d",
                   $realtime, got.hit, got.frame, got.evicted_valid, got.evicted_page,
                   got.fault_total);
        return;
      end
      want = owed_results.pop_front();
      if (got.hit !== want.hit || got.frame !== want.frame ||
          got.evicted_valid !== want.evicted_valid || got.evicted_page !== want.evicted_page ||
          got.fault_total !== want.fault_total) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] word %0d: exp hit=%0b frame=%0d ev=%0b page=%h faults=%0d | got hit=%0b frame=%0d ev=%0b page=%h faults=%0d",
                   $realtime, words_checked, want.hit, want.frame, want.evicted_valid,
                   want.evicted_page, want.fault_total, got.hit, got.frame,
                   got.evicted_valid, got.evicted_page, got.fault_total);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_PAGE_SHIFT;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [ADDR_W-1:0]     virtual_address_i = '0;
  logic                  is_write_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  hit_o;
  logic [FRAME_OUT_W-1:0] frame_o;
  logic                  evicted_valid_o;
  logic [PAGE_W-1:0]     evicted_page_o;
  logic [FAULT_W-1:0]    fault_total_o;

  frame_table_scoreboard sb;
  int unsigned send_idle_pct = 26;
  int unsigned recv_idle_pct = 61;
  int unsigned stall_hold    = 0;
  int unsigned cycle_count   = 0;
  int          settings_seen = 1;

  nru_page_replacement DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .virtual_address_i(virtual_address_i),
    .is_write_i       (is_write_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hit_o            (hit_o),
    .frame_o          (frame_o),
    .evicted_valid_o  (evicted_valid_o),
    .evicted_page_o   (evicted_page_o),
    .fault_total_o    (fault_total_o)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: a long hold-off wins over random stalls; advance at the falling edge.
  always @(negedge clk_i) begin
    if (stall_hold != 0) begin
      out_stall_i <= 1'b1;
      stall_hold  <= stall_hold - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Take each accepted result word and check it against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{hit: hit_o, frame: frame_o, evicted_valid: evicted_valid_o,
                        evicted_page: evicted_page_o, fault_total: fault_total_o});
  end

  // Offer one access word; returns at the falling edge after it is accepted with valid
  // still high, so the next call can replace the payload without a glitch on valid.
  task automatic send_access(input logic [ADDR_W-1:0] addr, input logic wr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    virtual_address_i <= addr;
    is_write_i        <= wr;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_access(addr, wr);
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every owed result has come back.
  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    while (sb.owed_results.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Write one register; junk above the register width must be ignored.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                           input int width);
    logic [CFG_DATA_W-1:0] data;
    logic [CFG_DATA_W-1:0] keep;
    keep        = (width >= CFG_DATA_W) ? '1 : ((CFG_DATA_W'(1) << width) - 1'b1);
    data        = (CFG_DATA_W'(value) & keep) | (CFG_DATA_W'($urandom()) & ~keep);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic configure(input int unsigned shift, input int unsigned frames,
                           input int unsigned interval);
    wait_results_done();
    write_reg(CFG_PAGE_SHIFT, shift, SHIFT_W);
    write_reg(CFG_FRAMES_IN_USE, frames, FIU_W);
    write_reg(CFG_CLEAR_INTERVAL, interval, CLR_W);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    settings_seen++;
  endtask

  // Mostly addresses from a small page pool so hits and NRU evictions both happen;
  // a few fully random addresses toggle every address bit.
  function automatic logic [ADDR_W-1:0] pick_address(input int unsigned span,
                                                     input logic [PAGE_W-1:0] base);
    logic [PAGE_W-1:0] page;
    logic [ADDR_W-1:0] offs;
    page = base + PAGE_W'($urandom_range(span - 1));
    offs = $urandom() & ((ADDR_W'(1) << sb.page_shift) - 1'b1);
    if ($urandom_range(99) < 8) return $urandom();
    return (page << sb.page_shift) | offs;
  endfunction

  initial begin
    int unsigned       shift;
    int unsigned       frames;
    int unsigned       interval;
    int unsigned       span;
    logic [PAGE_W-1:0] base;
    sb = new();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at reset settings: shift 6, 16 frames, clear every 8 accesses.
    send_access(32'h0000_0000, 1'b0);  // page zero is a real page, not an empty mark
    send_access(32'h0000_003F, 1'b1);  // same page: hit that sets M
    send_access(32'hFFFF_FFFF, 1'b1);  // top page
    send_access(32'hFFFF_FFC0, 1'b0);  // hit on the top page
    for (int k = 2; k < 16; k++)
      send_access((ADDR_W'(k) << 6) | ADDR_W'(k), k[0]);  // fill every frame
    send_access(32'h0000_4000, 1'b0);  // table full: first NRU eviction
    send_access(32'h0000_4040, 1'b1);
    send_access(32'h0000_0010, 1'b0);  // page zero is still resident: hit
    send_access(32'h0000_4000, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      // Idling profile: sender light/receiver heavy, then swapped, then none.
      if (p < 4) begin
        send_idle_pct = 26;
        recv_idle_pct = 61;
      end else if (p < 8) begin
        send_idle_pct = 61;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0:  begin shift = 0;  frames = 1;  interval = 1;     end
        1:  begin shift = 15; frames = 31; interval = 0;     end  // above range acts as 16
        2:  begin shift = 10; frames = 16; interval = 65535; end
        3:  begin shift = 6;  frames = 4;  interval = 3;     end  // interval under the counter
        4:  begin shift = 12; frames = 0;  interval = 2;     end  // zero acts as one frame
        5:  begin shift = 4;  frames = 8;  interval = 5;     end  // hidden frames come back
        6:  begin shift = 8;  frames = 17; interval = 20;    end
        9:  begin shift = 2;  frames = 2;  interval = 1;     end
        default: begin
          shift    = $urandom_range(15);
          frames   = $urandom_range(31);
          interval = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(40);
        end
      endcase
      configure(shift, frames, interval);
      span = sb.effective_frames() + $urandom_range(6);
      base = $urandom();
      for (int w = 0; w < WORDS_PER_PHASE; w++) begin
        // Hold the receiver off long enough to back the block up into its input.
        if (p == 1 && w == 40) stall_hold = LONG_HOLD;
        // Pause the sender until the block has returned everything.
        if (p == 1 && w == 100) wait_results_done();
        // Shift the working set now and then so old pages age out.
        if ($urandom_range(49) == 0) base = base + PAGE_W'($urandom_range(4));
        send_access(pick_address(span, base), $urandom_range(1));
      end
    end

    in_valid_i <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Checked %0d result words over %0d register settings (%0d hits, %0d evictions).",
             sb.words_checked, settings_seen, sb.hits_seen, sb.evictions_seen);
    $display("Mismatches: %0d, predictions left over: %0d.",
             sb.mismatches, sb.owed_results.size());
    if (sb.mismatches == 0 && sb.owed_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* nru_page_replacement.f */
design/nru_pkg.sv
design/nru_ram.sv
design/nru_ctrl.sv
design/nru_dp.sv
design/nru_page_replacement.sv
design/nru_checker.sv
tb/tb.sv
